FILE: design/adpe_pkg.sv
// Shared types and constants for the data-processing execute pipeline.
// It has no dependencies. The decode, shift, ALU and top-level files import it.
package adpe_pkg;

    typedef enum logic [2:0] {
        OUT_EXEC      = 3'd0,
        OUT_COND_FAIL = 3'd1,
        OUT_R15_UNDEF = 3'd2,
        OUT_UNSUP     = 3'd3,
        OUT_COND_NV   = 3'd4
    } t_outcome;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } t_shift_kind;

    typedef enum logic [1:0] {
        ALU_AND = 2'd0,
        ALU_EOR = 2'd1,
        ALU_SUB = 2'd2
    } t_alu_op;

    typedef enum logic [3:0] {
        CC_EQ = 4'd0,  CC_NE = 4'd1,  CC_CS = 4'd2,  CC_CC = 4'd3,
        CC_MI = 4'd4,  CC_PL = 4'd5,  CC_VS = 4'd6,  CC_VC = 4'd7,
        CC_HI = 4'd8,  CC_LS = 4'd9,  CC_GE = 4'd10, CC_LT = 4'd11,
        CC_GT = 4'd12, CC_LE = 4'd13, CC_AL = 4'd14, CC_NV = 4'd15
    } t_cond;

    localparam logic [3:0] OPC_AND  = 4'h0;
    localparam logic [3:0] OPC_EOR  = 4'h1;
    localparam logic [3:0] OPC_SUB  = 4'h2;
    localparam logic [2:0] CLS_REG  = 3'b000;
    localparam logic [2:0] CLS_IMM  = 3'b001;
    localparam logic [3:0] REG_PC   = 4'hF;
    localparam logic [31:0] PC_AHEAD = 32'd8;
    localparam logic [7:0] SHIFT_32 = 8'd32;

    typedef struct packed {
        t_outcome    outcome;
        logic [3:0]  rd;
        logic        sbit;
        t_alu_op     op;
        logic [3:0]  flags;
        logic [31:0] a;
        logic [31:0] src;
        t_shift_kind kind;
        logic [7:0]  count;
        logic        rrx;
    } t_dec_stage;

    typedef struct packed {
        t_outcome    outcome;
        logic [3:0]  rd;
        logic        sbit;
        t_alu_op     op;
        logic [3:0]  flags;
        logic [31:0] a;
        logic [31:0] op2;
        logic        carry;
    } t_shf_stage;

endpackage

FILE: design/adpe_decode.sv
// First pipeline stage: condition test, instruction classification and operand selection.
// It uses the types and constants of adpe_pkg.
module adpe_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [31:0]         i_instruction,
    input  logic [31:0]         i_first_value,
    input  logic [31:0]         i_shift_source_value,
    input  logic [31:0]         i_shift_count_value,
    input  logic [31:0]         i_pc_value,
    input  logic [3:0]          i_flags_in,
    output logic                o_valid,
    output adpe_pkg::t_dec_stage o_stage
);
    import adpe_pkg::*;

    logic        r_valid;
    t_dec_stage  r_stage;
    t_dec_stage  n_stage;

    logic [3:0]  cond;
    logic [2:0]  cls;
    logic [3:0]  opc;
    logic [3:0]  rn;
    logic [3:0]  rd;
    logic [3:0]  rs;
    logic [3:0]  rm;
    logic [4:0]  imm_shift;
    logic [31:0] pc8;
    logic        cond_ok;
    logic        unsup;
    logic        r15_undef;
    logic        fn;
    logic        fz;
    logic        fc;
    logic        fv;

    assign cond      = i_instruction[31:28];
    assign cls       = i_instruction[27:25];
    assign opc       = i_instruction[24:21];
    assign rn        = i_instruction[19:16];
    assign rd        = i_instruction[15:12];
    assign rs        = i_instruction[11:8];
    assign rm        = i_instruction[3:0];
    assign imm_shift = i_instruction[11:7];
    assign pc8       = i_pc_value + PC_AHEAD;
    assign fn        = i_flags_in[3];
    assign fz        = i_flags_in[2];
    assign fc        = i_flags_in[1];
    assign fv        = i_flags_in[0];

    always_comb begin
        case (t_cond'(cond))
            CC_EQ:   cond_ok = fz;
            CC_NE:   cond_ok = !fz;
            CC_CS:   cond_ok = fc;
            CC_CC:   cond_ok = !fc;
            CC_MI:   cond_ok = fn;
            CC_PL:   cond_ok = !fn;
            CC_VS:   cond_ok = fv;
            CC_VC:   cond_ok = !fv;
            CC_HI:   cond_ok = fc && !fz;
            CC_LS:   cond_ok = !fc || fz;
            CC_GE:   cond_ok = (fn == fv);
            CC_LT:   cond_ok = (fn != fv);
            CC_GT:   cond_ok = !fz && (fn == fv);
            CC_LE:   cond_ok = fz || (fn != fv);
            default: cond_ok = 1'b1;
        endcase
    end

    assign unsup = ((cls != CLS_REG) && (cls != CLS_IMM))
                || ((cls == CLS_REG) && i_instruction[7] && i_instruction[4])
                || ((opc != OPC_AND) && (opc != OPC_EOR) && (opc != OPC_SUB));

    assign r15_undef = (cls == CLS_REG) && i_instruction[4]
                    && ((rn == REG_PC) || (rm == REG_PC) || (rs == REG_PC) || (rd == REG_PC));

    always_comb begin
        n_stage.rd    = rd;
        n_stage.sbit  = i_instruction[20];
        n_stage.flags = i_flags_in;
        n_stage.a     = (rn == REG_PC) ? pc8 : i_first_value;

        if (t_cond'(cond) == CC_NV) begin
            n_stage.outcome = OUT_COND_NV;
        end else if (!cond_ok) begin
            n_stage.outcome = OUT_COND_FAIL;
        end else if (unsup) begin
            n_stage.outcome = OUT_UNSUP;
        end else if (r15_undef) begin
            n_stage.outcome = OUT_R15_UNDEF;
        end else begin
            n_stage.outcome = OUT_EXEC;
        end

        case (opc)
            OPC_AND: n_stage.op = ALU_AND;
            OPC_EOR: n_stage.op = ALU_EOR;
            default: n_stage.op = ALU_SUB;
        endcase

        // Every operand form is mapped onto register-shift semantics for the next stage.
        n_stage.rrx = 1'b0;
        if (cls == CLS_IMM) begin
            n_stage.src   = {24'd0, i_instruction[7:0]};
            n_stage.kind  = SH_ROR;
            n_stage.count = {3'd0, i_instruction[11:8], 1'b0};
        end else if (!i_instruction[4]) begin
            n_stage.src  = (rm == REG_PC) ? pc8 : i_shift_source_value;
            n_stage.kind = t_shift_kind'(i_instruction[6:5]);
            if ((imm_shift == 5'd0)
                && ((n_stage.kind == SH_LSR) || (n_stage.kind == SH_ASR))) begin
                n_stage.count = SHIFT_32;
            end else begin
                n_stage.count = {3'd0, imm_shift};
            end
            n_stage.rrx = (imm_shift == 5'd0) && (n_stage.kind == SH_ROR);
        end else begin
            n_stage.src   = (rm == REG_PC) ? pc8 : i_shift_source_value;
            n_stage.kind  = t_shift_kind'(i_instruction[6:5]);
            n_stage.count = i_shift_count_value[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

FILE: design/adpe_shift.sv
// Second pipeline stage: barrel shifter forming the shifter operand and its carry-out.
// It uses the types and constants of adpe_pkg.
module adpe_shift (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  adpe_pkg::t_dec_stage i_stage,
    output logic                 o_valid,
    output adpe_pkg::t_shf_stage o_stage
);
    import adpe_pkg::*;

    logic        r_valid;
    t_shf_stage  r_stage;
    t_shf_stage  n_stage;

    logic [31:0] m;
    logic [4:0]  r;
    logic        cin;
    logic        below32;
    logic [32:0] lsl_full;
    logic [32:0] lsr_full;
    logic [32:0] asr_full;
    logic [63:0] ror_full;

    assign m        = i_stage.src;
    assign r        = i_stage.count[4:0];
    assign cin      = i_stage.flags[1];
    assign below32  = (i_stage.count[7:5] == 3'd0);
    assign lsl_full = {1'b0, m} << r;
    assign lsr_full = {m, 1'b0} >> r;
    assign asr_full = $unsigned($signed({m, 1'b0}) >>> r);
    assign ror_full = {m, m} >> r;

    always_comb begin
        n_stage.outcome = i_stage.outcome;
        n_stage.rd      = i_stage.rd;
        n_stage.sbit    = i_stage.sbit;
        n_stage.op      = i_stage.op;
        n_stage.flags   = i_stage.flags;
        n_stage.a       = i_stage.a;

        if (i_stage.rrx) begin
            n_stage.op2   = {cin, m[31:1]};
            n_stage.carry = m[0];
        end else if (i_stage.count == 8'd0) begin
            n_stage.op2   = m;
            n_stage.carry = cin;
        end else begin
            case (i_stage.kind)
                SH_LSL: begin
                    if (below32) begin
                        n_stage.op2   = lsl_full[31:0];
                        n_stage.carry = lsl_full[32];
                    end else begin
                        n_stage.op2   = 32'd0;
                        n_stage.carry = (i_stage.count == SHIFT_32) ? m[0] : 1'b0;
                    end
                end
                SH_LSR: begin
                    if (below32) begin
                        n_stage.op2   = lsr_full[32:1];
                        n_stage.carry = lsr_full[0];
                    end else begin
                        n_stage.op2   = 32'd0;
                        n_stage.carry = (i_stage.count == SHIFT_32) ? m[31] : 1'b0;
                    end
                end
                SH_ASR: begin
                    if (below32) begin
                        n_stage.op2   = asr_full[32:1];
                        n_stage.carry = asr_full[0];
                    end else begin
                        n_stage.op2   = {32{m[31]}};
                        n_stage.carry = m[31];
                    end
                end
                default: begin
                    n_stage.op2   = ror_full[31:0];
                    n_stage.carry = ror_full[31];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

FILE: design/adpe_alu.sv
// Third pipeline stage: AND, EOR and SUB with flag generation and the output register.
// It uses the types and constants of adpe_pkg.
module adpe_alu (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  adpe_pkg::t_shf_stage i_stage,
    output logic                 o_valid,
    output logic [2:0]           o_outcome,
    output logic [31:0]          o_result_value,
    output logic [3:0]           o_dest_reg,
    output logic                 o_write_reg,
    output logic [3:0]           o_flags_out
);
    import adpe_pkg::*;

    logic        r_valid;
    t_outcome    r_outcome;
    logic [31:0] r_result;
    logic [3:0]  r_dest;
    logic        r_write;
    logic [3:0]  r_flags;

    logic [31:0] n_result;
    logic        n_write;
    logic [3:0]  n_flags;

    logic [32:0] diff;
    logic [31:0] alu;
    logic        exec;
    logic        c_new;
    logic        v_new;

    assign diff = {1'b0, i_stage.a} - {1'b0, i_stage.op2};
    assign exec = (i_stage.outcome == OUT_EXEC);

    always_comb begin
        case (i_stage.op)
            ALU_AND: alu = i_stage.a & i_stage.op2;
            ALU_EOR: alu = i_stage.a ^ i_stage.op2;
            default: alu = diff[31:0];
        endcase

        if (i_stage.op == ALU_SUB) begin
            c_new = !diff[32];
            v_new = (i_stage.a[31] ^ i_stage.op2[31]) & (i_stage.a[31] ^ diff[31]);
        end else begin
            c_new = i_stage.carry;
            v_new = i_stage.flags[0];
        end

        n_result = exec ? alu : 32'd0;
        n_write  = exec;
        if (exec && i_stage.sbit && (i_stage.rd != REG_PC)) begin
            n_flags = {alu[31], (alu == 32'd0), c_new, v_new};
        end else begin
            n_flags = i_stage.flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_outcome <= i_stage.outcome;
            r_result  <= n_result;
            r_dest    <= i_stage.rd;
            r_write   <= n_write;
            r_flags   <= n_flags;
        end
    end

    assign o_valid        = r_valid;
    assign o_outcome      = r_outcome;
    assign o_result_value = r_result;
    assign o_dest_reg     = r_dest;
    assign o_write_reg    = r_write;
    assign o_flags_out    = r_flags;

endmodule

FILE: design/arm_data_processing_execute_core.sv
// Top level of the data-processing execute pipeline: decode, shift and ALU stages.
// It depends on adpe_pkg, adpe_decode, adpe_shift and adpe_alu.
//
// Usage:
// The input channel carries one data-processing instruction with its Rn, Rm and Rs values,
// its address and the current NZCV flags. A transfer takes place on a rising edge where
// i_valid is high and o_stall is low. The output channel returns one result for every
// input transfer: the outcome code, the ALU result, Rd, the write enable and the new
// flags. An output transfer takes place where o_valid is high and i_stall is low.
// An input transfer reaches o_valid after the decode, barrel shift and ALU register stages.
// Throughput is one instruction per cycle while i_stall is low; each stage is one register.
// Each stage advances when it is empty or the stage after it advances. When the receiver
// stalls, the pipeline fills and the results are held in place. o_stall rises only when
// all three stages hold instructions and the output is stalled. Bubbles close up while
// the output waits. A synchronous reset (i_rst_n low) clears all stage valid bits.
// The block keeps no other state.
module arm_data_processing_execute_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instruction,
    input  logic [31:0] i_first_value,
    input  logic [31:0] i_shift_source_value,
    input  logic [31:0] i_shift_count_value,
    input  logic [31:0] i_pc_value,
    input  logic [3:0]  i_flags_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_outcome,
    output logic [31:0] o_result_value,
    output logic [3:0]  o_dest_reg,
    output logic        o_write_reg,
    output logic [3:0]  o_flags_out
);
    import adpe_pkg::*;

    logic       dec_valid;
    logic       shf_valid;
    logic       en_dec;
    logic       en_shf;
    logic       en_alu;
    t_dec_stage dec_stage;
    t_shf_stage shf_stage;

    assign en_alu  = !o_valid || !i_stall;
    assign en_shf  = !shf_valid || en_alu;
    assign en_dec  = !dec_valid || en_shf;
    assign o_stall = !en_dec;

    adpe_decode u_decode (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_en                 (en_dec),
        .i_valid              (i_valid),
        .i_instruction        (i_instruction),
        .i_first_value        (i_first_value),
        .i_shift_source_value (i_shift_source_value),
        .i_shift_count_value  (i_shift_count_value),
        .i_pc_value           (i_pc_value),
        .i_flags_in           (i_flags_in),
        .o_valid              (dec_valid),
        .o_stage              (dec_stage)
    );

    adpe_shift u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_shf),
        .i_valid (dec_valid),
        .i_stage (dec_stage),
        .o_valid (shf_valid),
        .o_stage (shf_stage)
    );

    adpe_alu u_alu (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en_alu),
        .i_valid        (shf_valid),
        .i_stage        (shf_stage),
        .o_valid        (o_valid),
        .o_outcome      (o_outcome),
        .o_result_value (o_result_value),
        .o_dest_reg     (o_dest_reg),
        .o_write_reg    (o_write_reg),
        .o_flags_out    (o_flags_out)
    );

endmodule
